@@ rtl/cfru_pkg.sv @@
package cfru_pkg;

   // Host function codes
   localparam logic [2:0] FUNC_RX_BYTE    = 3'd0;
   localparam logic [2:0] FUNC_TAKE_STAT  = 3'd1;
   localparam logic [2:0] FUNC_READ_FRAME = 3'd2;
   localparam logic [2:0] FUNC_RELEASE    = 3'd3;
   localparam logic [2:0] FUNC_READ_TEXT  = 3'd4;
   localparam logic [2:0] FUNC_ACK_TEXT   = 3'd5;

   // Frame status codes
   localparam logic [1:0] STAT_NONE     = 2'd0;
   localparam logic [1:0] STAT_COMPLETE = 2'd1;
   localparam logic [1:0] STAT_READ_CMD = 2'd2;

   // Binary parser phases
   localparam logic [1:0] FPH_HUNT_SYNC0 = 2'd0;
   localparam logic [1:0] FPH_HUNT_SYNC1 = 2'd1;
   localparam logic [1:0] FPH_BODY       = 2'd2;

   // Text parser phases
   localparam logic [1:0] TPH_HUNT_AT = 2'd0;
   localparam logic [1:0] TPH_BODY    = 2'd1;
   localparam logic [1:0] TPH_WAIT_LF = 2'd2;

   // Framing characters
   localparam logic [7:0] SYNC0_BYTE = 8'hBC;
   localparam logic [7:0] SYNC1_BYTE = 8'hCD;
   localparam logic [7:0] AT_BYTE    = 8'h40;
   localparam logic [7:0] CR_BYTE    = 8'h0D;
   localparam logic [7:0] LF_BYTE    = 8'h0A;

   // Frame length table codes; real lengths run 8 to 45
   localparam logic [5:0] FLEN_UNKNOWN = 6'd0;
   localparam logic [5:0] FLEN_READ    = 6'd63;
   localparam logic [5:0] FLEN_MAX     = 6'd45;

   // One beat of work handed from the input register to both parsers
   typedef struct packed {
      logic       advance;
      logic [2:0] func;
      logic [7:0] rx_byte;
      logic [6:0] index;
   } cfru_op_type;

   typedef struct packed {
      logic [1:0] status;
      logic [6:0] count;
      logic [7:0] rd_data;
      logic       rd_sel;
   } cfru_frame_rsp_type;

   typedef struct packed {
      logic       ready;
      logic [7:0] length;
      logic [7:0] rd_data;
      logic       rd_sel;
   } cfru_text_rsp_type;

   // Command byte to frame length
   function automatic logic [5:0] frame_length(input logic [7:0] cmd);
      logic [5:0] len;
      unique case (cmd)
         8'hA8, 8'hBE, 8'hA5, 8'h80, 8'h04, 8'h02, 8'h15, 8'h11:
            len = 6'd8;
         8'hEA:
            len = 6'd9;
         8'h83, 8'h07:
            len = 6'd13;
         8'h9A, 8'hC5, 8'hD5, 8'hE5, 8'hE7, 8'hB5, 8'h13:
            len = 6'd17;
         8'hAF:
            len = 6'd19;
         8'hBD, 8'hBA:
            len = 6'd20;
         8'h9B, 8'h84, 8'h81, 8'h06:
            len = 6'd21;
         8'hA3, 8'hA4, 8'hAD:
            len = 6'd33;
         8'h82:
            len = FLEN_MAX;
         8'hBF, 8'hB2, 8'hF3, 8'hF4, 8'hF5, 8'hFB, 8'hFC, 8'hC1, 8'hAE, 8'hA7,
         8'hA6, 8'hFA, 8'hFD, 8'hBB, 8'hB6, 8'hC6, 8'hD6, 8'hE6, 8'hE8, 8'h10,
         8'h12, 8'h14, 8'h01, 8'h03, 8'h05:
            len = FLEN_READ;
         default:
            len = FLEN_UNKNOWN;
      endcase
      return len;
   endfunction

endpackage

@@ rtl/cfru_if.sv @@
// Request channel: host function plus received byte
interface cfru_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] func;
   logic [7:0] rx_byte;
   logic [6:0] index;

   modport source (output valid, func, rx_byte, index, input ready);
   modport sink   (input valid, func, rx_byte, index, output ready);
endinterface

// Response channel: parser status after each beat
interface cfru_rsp_if;
   logic       valid;
   logic       ready;
   logic [1:0] frame_status;
   logic [6:0] frame_count;
   logic       text_ready;
   logic [7:0] text_length;
   logic [7:0] data;

   modport source (output valid, frame_status, frame_count, text_ready, text_length, data,
                   input ready);
   modport sink   (input valid, frame_status, frame_count, text_ready, text_length, data,
                   output ready);
endinterface

@@ rtl/cfru_frame_parser.sv @@
module cfru_frame_parser #(
   parameter int FRAME_DEPTH = 64
) (
   input  logic                         clock,
   input  logic                         reset,
   input  cfru_pkg::cfru_op_type        op,
   output cfru_pkg::cfru_frame_rsp_type rsp
);

   localparam int FAW = $clog2(FRAME_DEPTH);

   logic [1:0]     phase_ff, phase_in;
   logic [7:0]     cmd_ff, cmd_in;
   logic [5:0]     count_ff, count_in;
   logic [1:0]     status_ff, status_in;
   logic [1:0]     status_rsp_ff, status_rsp_in;
   logic           rd_sel_ff, rd_sel_in;
   logic [7:0]     rd_data_ff;
   logic [7:0]     store [FRAME_DEPTH];
   logic [7:0]     cmd_eff;
   logic [5:0]     len;
   logic [5:0]     count_inc;
   logic           wr_en;
   logic [FAW-1:0] wr_addr;
   logic [FAW-1:0] rd_addr;
   logic [FAW+6:0] idx_wide;

   // Header hunt, body store and host functions
   always_comb begin
      phase_in  = phase_ff;
      cmd_in    = cmd_ff;
      count_in  = count_ff;
      status_in = status_ff;
      wr_en     = 1'b0;
      cmd_eff   = (count_ff == 6'd0) ? op.rx_byte : cmd_ff;
      len       = cfru_pkg::frame_length(cmd_eff);
      count_inc = count_ff + 6'd1;
      if (op.func == cfru_pkg::FUNC_RX_BYTE) begin
         unique case (phase_ff)
            cfru_pkg::FPH_HUNT_SYNC0: begin
               if (op.rx_byte == cfru_pkg::SYNC0_BYTE) phase_in = cfru_pkg::FPH_HUNT_SYNC1;
            end
            cfru_pkg::FPH_HUNT_SYNC1: begin
               if (op.rx_byte == cfru_pkg::SYNC1_BYTE) begin
                  phase_in  = cfru_pkg::FPH_BODY;
                  count_in  = 6'd0;
                  status_in = cfru_pkg::STAT_NONE;
               end else begin
                  phase_in = cfru_pkg::FPH_HUNT_SYNC0;
               end
            end
            cfru_pkg::FPH_BODY: begin
               wr_en  = (32'(count_ff) < FRAME_DEPTH);
               cmd_in = cmd_eff;
               if (len == cfru_pkg::FLEN_READ) begin
                  phase_in  = cfru_pkg::FPH_HUNT_SYNC0;
                  count_in  = 6'd1;
                  status_in = cfru_pkg::STAT_READ_CMD;
               end else if (len != cfru_pkg::FLEN_UNKNOWN) begin
                  count_in = count_inc;
                  if (count_inc >= len) begin
                     phase_in  = cfru_pkg::FPH_HUNT_SYNC0;
                     status_in = cfru_pkg::STAT_COMPLETE;
                  end
               end
            end
            default: ;
         endcase
      end
      if (op.func == cfru_pkg::FUNC_RELEASE) count_in = 6'd0;
      // take-status reports the old value and clears it
      status_rsp_in = status_in;
      if (op.func == cfru_pkg::FUNC_TAKE_STAT) begin
         status_rsp_in = status_ff;
         status_in     = cfru_pkg::STAT_NONE;
      end
      rd_sel_in = (op.func == cfru_pkg::FUNC_READ_FRAME) && (32'(op.index) < FRAME_DEPTH);
      idx_wide  = {{FAW{1'b0}}, op.index};
      rd_addr   = idx_wide[FAW-1:0];
      wr_addr   = FAW'(count_ff);
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= cfru_pkg::FPH_HUNT_SYNC0;
         cmd_ff        <= 8'd0;
         count_ff      <= 6'd0;
         status_ff     <= cfru_pkg::STAT_NONE;
         status_rsp_ff <= cfru_pkg::STAT_NONE;
         rd_sel_ff     <= 1'b0;
      end else if (op.advance) begin
         phase_ff      <= phase_in;
         cmd_ff        <= cmd_in;
         count_ff      <= count_in;
         status_ff     <= status_in;
         status_rsp_ff <= status_rsp_in;
         rd_sel_ff     <= rd_sel_in;
      end
   end

   // Frame buffer, at most one write and one registered read per beat
   always_ff @(posedge clock) begin
      if (op.advance) begin
         if (wr_en) store[wr_addr] <= op.rx_byte;
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rsp.status  = status_rsp_ff;
   assign rsp.count   = 7'(count_ff);
   assign rsp.rd_data = rd_data_ff;
   assign rsp.rd_sel  = rd_sel_ff;

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= cfru_pkg::FLEN_MAX)
      else $error("frame count beyond longest frame");

   a_read_cmd_count: assert property (@(posedge clock) disable iff (reset)
      op.advance && op.func == cfru_pkg::FUNC_RX_BYTE && phase_ff == cfru_pkg::FPH_BODY
      && len == cfru_pkg::FLEN_READ |=> count_ff == 6'd1 && status_ff == cfru_pkg::STAT_READ_CMD)
      else $error("read command did not close frame");

   a_take_clears: assert property (@(posedge clock) disable iff (reset)
      op.advance && op.func == cfru_pkg::FUNC_TAKE_STAT
      |=> status_ff == cfru_pkg::STAT_NONE && status_rsp_ff == $past(status_ff))
      else $error("take status mishandled");

endmodule

@@ rtl/cfru_text_parser.sv @@
module cfru_text_parser #(
   parameter int TEXT_DEPTH = 128
) (
   input  logic                        clock,
   input  logic                        reset,
   input  cfru_pkg::cfru_op_type       op,
   output cfru_pkg::cfru_text_rsp_type rsp
);

   localparam int TAW = $clog2(TEXT_DEPTH);
   localparam int PW  = $clog2(TEXT_DEPTH + 1);

   logic [1:0]     phase_ff, phase_in;
   logic [PW-1:0]  pos_ff, pos_in;
   logic           flag_ff, flag_in;
   logic           rd_sel_ff, rd_sel_in;
   logic [7:0]     rd_data_ff;
   logic [7:0]     store [TEXT_DEPTH];
   logic           wr_en;
   logic [TAW-1:0] rd_addr;
   logic [TAW+6:0] idx_wide;

   // '@' start, store until CR LF, hold ready until ack
   always_comb begin
      phase_in = phase_ff;
      pos_in   = pos_ff;
      flag_in  = flag_ff;
      wr_en    = 1'b0;
      if (op.func == cfru_pkg::FUNC_RX_BYTE) begin
         unique case (phase_ff)
            cfru_pkg::TPH_HUNT_AT: begin
               if (op.rx_byte == cfru_pkg::AT_BYTE && !flag_ff) begin
                  phase_in = cfru_pkg::TPH_BODY;
                  pos_in   = '0;
               end
            end
            cfru_pkg::TPH_BODY: begin
               if (op.rx_byte == cfru_pkg::CR_BYTE) begin
                  phase_in = cfru_pkg::TPH_WAIT_LF;
               end else if (32'(pos_ff) < TEXT_DEPTH) begin
                  wr_en  = 1'b1;
                  pos_in = pos_ff + PW'(1);
               end
            end
            cfru_pkg::TPH_WAIT_LF: begin
               if (op.rx_byte == cfru_pkg::LF_BYTE) begin
                  phase_in = cfru_pkg::TPH_HUNT_AT;
                  flag_in  = 1'b1;
               end
            end
            default: ;
         endcase
      end
      if (op.func == cfru_pkg::FUNC_ACK_TEXT) flag_in = 1'b0;
      rd_sel_in = (op.func == cfru_pkg::FUNC_READ_TEXT) && (32'(op.index) < TEXT_DEPTH);
      idx_wide  = {{TAW{1'b0}}, op.index};
      rd_addr   = idx_wide[TAW-1:0];
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= cfru_pkg::TPH_HUNT_AT;
         pos_ff    <= '0;
         flag_ff   <= 1'b0;
         rd_sel_ff <= 1'b0;
      end else if (op.advance) begin
         phase_ff  <= phase_in;
         pos_ff    <= pos_in;
         flag_ff   <= flag_in;
         rd_sel_ff <= rd_sel_in;
      end
   end

   // Text buffer, at most one write and one registered read per beat
   always_ff @(posedge clock) begin
      if (op.advance) begin
         if (wr_en) store[pos_ff[TAW-1:0]] <= op.rx_byte;
         rd_data_ff <= store[rd_addr];
      end
   end

   assign rsp.ready   = flag_ff;
   assign rsp.length  = 8'(pos_ff);
   assign rsp.rd_data = rd_data_ff;
   assign rsp.rd_sel  = rd_sel_ff;

   a_pos_bound: assert property (@(posedge clock) disable iff (reset)
      32'(pos_ff) <= TEXT_DEPTH)
      else $error("text position beyond capacity");

   a_no_start_while_pending: assert property (@(posedge clock) disable iff (reset)
      flag_ff && phase_ff == cfru_pkg::TPH_HUNT_AT && op.func != cfru_pkg::FUNC_ACK_TEXT
      |=> phase_ff == cfru_pkg::TPH_HUNT_AT)
      else $error("text started while previous packet pending");

   a_lf_raises_ready: assert property (@(posedge clock) disable iff (reset)
      op.advance && op.func == cfru_pkg::FUNC_RX_BYTE && phase_ff == cfru_pkg::TPH_WAIT_LF
      && op.rx_byte == cfru_pkg::LF_BYTE |=> flag_ff)
      else $error("text ready not raised on line end");

endmodule

@@ rtl/command_frame_receiver_unit.sv @@
// Command frame receiver. Each request beat carries one host function: a received
// byte (fed to both the binary frame parser and the '@'...CR LF text parser), take
// status, read a frame or text entry, release the frame buffer, or acknowledge text.
// Every request gives exactly one response beat with the parser state after it.
// One beat is accepted per clock while responses are taken. A request waits in the
// input register; its response is presented from the result register, which also
// holds the registered read data of the frame and text buffers, each written at most
// once per beat. The input register can still take one beat while a response
// waits, then holds off. Buffer entries read before ever being written return
// arbitrary data; there is no clearing pass after reset.
module command_frame_receiver_unit #(
   parameter int FRAME_DEPTH = 64,
   parameter int TEXT_DEPTH  = 128
) (
   input logic        clock,
   input logic        reset,
   cfru_req_if.sink   req_chan,
   cfru_rsp_if.source rsp_chan
);

   logic       s1_valid_ff;
   logic [2:0] s1_func_ff;
   logic [7:0] s1_byte_ff;
   logic [6:0] s1_index_ff;
   logic       rsp_valid_ff;
   logic       advance;
   logic       req_take;

   cfru_pkg::cfru_op_type        op;
   cfru_pkg::cfru_frame_rsp_type frame_rsp;
   cfru_pkg::cfru_text_rsp_type  text_rsp;

   // Move a beat into the result register whenever that slot frees up
   assign advance            = s1_valid_ff && (!rsp_valid_ff || rsp_chan.ready);
   assign req_chan.ready     = !s1_valid_ff || advance;
   assign req_take           = req_chan.valid && req_chan.ready;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (req_chan.ready) begin
         s1_valid_ff <= req_chan.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff  <= req_chan.func;
         s1_byte_ff  <= req_chan.rx_byte;
         s1_index_ff <= req_chan.index;
      end
   end

   // Response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (advance) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_chan.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   assign op.advance = advance;
   assign op.func    = s1_func_ff;
   assign op.rx_byte = s1_byte_ff;
   assign op.index   = s1_index_ff;

   cfru_frame_parser #(.FRAME_DEPTH(FRAME_DEPTH)) u_frame (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .rsp   (frame_rsp)
   );

   cfru_text_parser #(.TEXT_DEPTH(TEXT_DEPTH)) u_text (
      .clock (clock),
      .reset (reset),
      .op    (op),
      .rsp   (text_rsp)
   );

   // Response payload
   assign rsp_chan.valid        = rsp_valid_ff;
   assign rsp_chan.frame_status = frame_rsp.status;
   assign rsp_chan.frame_count  = frame_rsp.count;
   assign rsp_chan.text_ready   = text_rsp.ready;
   assign rsp_chan.text_length  = text_rsp.length;
   assign rsp_chan.data         = frame_rsp.rd_sel ? frame_rsp.rd_data :
                                  text_rsp.rd_sel  ? text_rsp.rd_data  : 8'd0;

   a_advance_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      advance |=> rsp_valid_ff)
      else $error("advanced beat lost before response");

   a_one_read_source: assert property (@(posedge clock) disable iff (reset)
      !(frame_rsp.rd_sel && text_rsp.rd_sel))
      else $error("frame and text reads selected together");

   a_stalled_beat_held: assert property (@(posedge clock) disable iff (reset)
      s1_valid_ff && !advance |=> s1_valid_ff && $stable(s1_func_ff))
      else $error("pending request beat dropped");

endmodule
